// ----- src/lht_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package lht_pkg;

	localparam int NUM_BKT    = 64;
	localparam int BKT_W      = $clog2(NUM_BKT);
	localparam int SLOTS      = 16;
	localparam int SLOT_W     = $clog2(SLOTS);
	localparam int FILL_W     = SLOT_W + 1;
	localparam int ADDR_W     = BKT_W + SLOT_W;
	localparam int KEY_W      = 32;
	localparam int CNT_W      = 7;
	localparam int REC_W      = 11;
	localparam int MOD_W      = BKT_W + 2;
	localparam int DIV_BITS   = 4;
	localparam int DIV_CYC    = KEY_W / DIV_BITS;
	localparam int DIVC_W     = $clog2(DIV_CYC);
	localparam int CAP_W      = 4;
	localparam int LIM_W      = 7;
	localparam int PROD_W     = LIM_W + CNT_W;
	localparam int LOAD_W     = 18;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	localparam logic [CFG_IDX_W-1:0] CFG_INIT_BKT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT    = 2'd2;

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_LOOKUP = 1'b1;

	localparam logic [CNT_W-1:0]  RST_INIT_BKT = 7'd3;
	localparam logic [CAP_W-1:0]  RST_CAP      = 4'd4;
	localparam logic [LIM_W-1:0]  RST_LIMIT    = 7'd75;
	localparam logic [LOAD_W-1:0] PCT_SCALE    = 18'd100;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_ADDR,
		ST_DIV,
		ST_ADDR_RES,
		ST_FILL_RD,
		ST_FILL_WAIT,
		ST_LK_RD,
		ST_LK_CMP,
		ST_INS,
		ST_LIM1,
		ST_LIM2,
		ST_SP_FILL_RD,
		ST_SP_FILL_WAIT,
		ST_SP_RD,
		ST_SP_DATA,
		ST_SP_DIV,
		ST_SP_MOVE,
		ST_SP_END_P,
		ST_SP_END_Q,
		ST_OUT
	} state_t;

	function automatic logic [CNT_W-1:0] clamp_buckets(input logic [CNT_W-1:0] v);
		logic [CNT_W-1:0] r;
		r = v;
		if (v == '0)
			r = CNT_W'(1);
		else if (v > CNT_W'(NUM_BKT))
			r = CNT_W'(NUM_BKT);
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- src/lht_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface lht_req_if;
	logic                      valid;
	logic                      ready;
	logic                      req_type;
	logic [lht_pkg::KEY_W-1:0] key;
	modport source (output valid, req_type, key, input ready);
	modport sink (input valid, req_type, key, output ready);
endinterface

interface lht_rsp_if;
	logic                      valid;
	logic                      ready;
	logic                      found;
	logic                      status;
	logic [lht_pkg::BKT_W-1:0] bucket_index;
	logic [lht_pkg::CNT_W-1:0] bucket_total;
	logic [lht_pkg::REC_W-1:0] record_total;
	modport source (output valid, found, status, bucket_index, bucket_total, record_total,
		input ready);
	modport sink (input valid, found, status, bucket_index, bucket_total, record_total,
		output ready);
endinterface

`default_nettype wire

// ----- src/lht_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ----- src/linear_hash_table.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Linear-hashing key table.
// req carries one transaction per operation: req_type selects insert or
// lookup of key. rsp returns one transaction per request with found,
// status (insert dropped, bucket slots full), the bucket address after any
// splits, and the bucket and record totals after the operation.
// The cfg port writes initial_buckets (index 0, restarts the table empty),
// bucket_capacity (1) and load_limit_pct (2); write only while idle.
// One operation is in flight at a time. The bucket address comes from a
// 4-bit-per-cycle remainder unit plus control states. A lookup then reads
// its bucket from the key RAM, a read and a compare per stored key. An
// insert writes the key and fill count, checks the load limit and, after
// any splits, recomputes the address; each split passes every key of its
// bucket through the remainder unit. Reset restores the register defaults
// and an empty table with 3 buckets; no clearing pass is needed. A finished
// result waits in the output register while the next request is taken;
// the block stalls only when a second result is ready before it drains.

module linear_hash_table (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [lht_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [lht_pkg::CFG_DATA_W-1:0]   cfg_data,
	lht_req_if.sink                               req,
	lht_rsp_if.source                             rsp
);

	lht_pkg::state_t state_q, state_nxt;

	logic [lht_pkg::CNT_W-1:0]  n_q;
	logic [lht_pkg::CAP_W-1:0]  cap_q;
	logic [lht_pkg::LIM_W-1:0]  lim_q;
	logic [2:0]                 level_q;
	logic [lht_pkg::BKT_W-1:0]  split_ptr_q;
	logic [lht_pkg::CNT_W-1:0]  bucket_cnt_q;
	logic [lht_pkg::REC_W-1:0]  key_cnt_q;
	logic [lht_pkg::NUM_BKT-1:0] vld_q;

	logic                        type_q;
	logic [lht_pkg::KEY_W-1:0]  key_q;
	logic                        fin_q;
	logic [lht_pkg::BKT_W-1:0]  bkt_q;
	logic [lht_pkg::FILL_W-1:0] fill_q;
	logic [lht_pkg::FILL_W-1:0] idx_q;
	logic [lht_pkg::FILL_W-1:0] keep_q;
	logic [lht_pkg::FILL_W-1:0] fillq_q;
	logic                        found_q;
	logic                        status_q;
	logic [lht_pkg::KEY_W-1:0]  mv_key_q;
	logic [lht_pkg::LOAD_W-1:0] lhs_q;
	logic [lht_pkg::PROD_W-1:0] prod_q;

	logic [lht_pkg::KEY_W-1:0]  div_num_q;
	logic [lht_pkg::MOD_W-1:0]  div_rem_q;
	logic [lht_pkg::MOD_W-1:0]  div_d_q;
	logic [lht_pkg::DIVC_W-1:0] div_cnt_q;
	logic [lht_pkg::KEY_W-1:0]  div_num_nxt;
	logic [lht_pkg::MOD_W-1:0]  div_rem_nxt;

	logic                        out_valid_q;
	logic                        out_found_q;
	logic                        out_status_q;
	logic [lht_pkg::BKT_W-1:0]  out_bkt_q;
	logic [lht_pkg::CNT_W-1:0]  out_btot_q;
	logic [lht_pkg::REC_W-1:0]  out_rtot_q;

	logic                        key_we;
	logic [lht_pkg::ADDR_W-1:0] key_waddr, key_raddr;
	logic [lht_pkg::KEY_W-1:0]  key_wdata, key_rdata;
	logic                        fill_we;
	logic [lht_pkg::BKT_W-1:0]  fill_waddr, fill_raddr;
	logic [lht_pkg::FILL_W-1:0] fill_wdata, fill_rdata;

	logic [lht_pkg::MOD_W-1:0]  rnd_m, rnd_m2, a1, a_sel;
	logic [lht_pkg::BKT_W-1:0]  bkt_nxt;
	logic [lht_pkg::FILL_W-1:0] fill_cur;
	logic [lht_pkg::LOAD_W-1:0] rhs;
	logic                        out_free;
	logic                        split_go;
	logic [lht_pkg::CNT_W-1:0]  ptr_inc;

	lht_ram #(.WIDTH(lht_pkg::KEY_W), .DEPTH(lht_pkg::NUM_BKT * lht_pkg::SLOTS)) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (key_waddr),
		.wdata (key_wdata),
		.raddr (key_raddr),
		.rdata (key_rdata)
	);

	lht_ram #(.WIDTH(lht_pkg::FILL_W), .DEPTH(lht_pkg::NUM_BKT)) u_fill_ram (
		.clk   (clk),
		.we    (fill_we),
		.waddr (fill_waddr),
		.wdata (fill_wdata),
		.raddr (fill_raddr),
		.rdata (fill_rdata)
	);

	assign rnd_m    = lht_pkg::MOD_W'(n_q) << level_q;
	assign rnd_m2   = rnd_m << 1;
	assign a1       = (div_rem_q >= rnd_m) ? div_rem_q - rnd_m : div_rem_q;
	assign a_sel    = (a1 < lht_pkg::MOD_W'(split_ptr_q)) ? div_rem_q : a1;
	assign bkt_nxt  = (a_sel >= lht_pkg::MOD_W'(lht_pkg::NUM_BKT)) ?
		lht_pkg::BKT_W'(lht_pkg::NUM_BKT - 1) : a_sel[lht_pkg::BKT_W-1:0];
	assign fill_cur = vld_q[fill_raddr] ? fill_rdata : '0;
	assign rhs      = lht_pkg::LOAD_W'(prod_q) * lht_pkg::LOAD_W'(cap_q);
	assign out_free = !out_valid_q || rsp.ready;
	assign split_go = (bucket_cnt_q < lht_pkg::CNT_W'(lht_pkg::NUM_BKT)) && (lhs_q >= rhs);
	assign ptr_inc  = lht_pkg::CNT_W'(split_ptr_q) + 1'b1;

	assign req.ready        = (state_q == lht_pkg::ST_IDLE);
	assign rsp.valid        = out_valid_q;
	assign rsp.found        = out_found_q;
	assign rsp.status       = out_status_q;
	assign rsp.bucket_index = out_bkt_q;
	assign rsp.bucket_total = out_btot_q;
	assign rsp.record_total = out_rtot_q;

	// remainder unit: four restoring steps per cycle
	always_comb begin
		logic [lht_pkg::MOD_W:0] t;
		div_num_nxt = div_num_q;
		div_rem_nxt = div_rem_q;
		for (int j = 0; j < lht_pkg::DIV_BITS; j++) begin
			t = {div_rem_nxt, div_num_nxt[lht_pkg::KEY_W-1]};
			div_num_nxt = div_num_nxt << 1;
			if (t >= {1'b0, div_d_q})
				div_rem_nxt = lht_pkg::MOD_W'(t - {1'b0, div_d_q});
			else
				div_rem_nxt = t[lht_pkg::MOD_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= lht_pkg::ST_IDLE;
		else
			state_q <= state_nxt;
	end

	always_comb begin
		state_nxt  = state_q;
		key_we     = 1'b0;
		key_waddr  = {bkt_q, fill_q[lht_pkg::SLOT_W-1:0]};
		key_wdata  = key_q;
		key_raddr  = {bkt_q, idx_q[lht_pkg::SLOT_W-1:0]};
		fill_we    = 1'b0;
		fill_waddr = bkt_q;
		fill_wdata = fill_q + 1'b1;
		fill_raddr = bkt_q;
		case (state_q)
			lht_pkg::ST_IDLE: begin
				if (req.valid)
					state_nxt = lht_pkg::ST_ADDR;
			end
			lht_pkg::ST_ADDR: state_nxt = lht_pkg::ST_DIV;
			lht_pkg::ST_DIV: begin
				if (div_cnt_q == lht_pkg::DIVC_W'(lht_pkg::DIV_CYC - 1))
					state_nxt = lht_pkg::ST_ADDR_RES;
			end
			lht_pkg::ST_ADDR_RES: state_nxt = fin_q ? lht_pkg::ST_OUT : lht_pkg::ST_FILL_RD;
			lht_pkg::ST_FILL_RD: state_nxt = lht_pkg::ST_FILL_WAIT;
			lht_pkg::ST_FILL_WAIT: begin
				if (type_q == lht_pkg::REQ_LOOKUP)
					state_nxt = (fill_cur == '0) ? lht_pkg::ST_OUT : lht_pkg::ST_LK_RD;
				else
					state_nxt = (fill_cur >= lht_pkg::FILL_W'(lht_pkg::SLOTS)) ?
						lht_pkg::ST_OUT : lht_pkg::ST_INS;
			end
			lht_pkg::ST_LK_RD: state_nxt = lht_pkg::ST_LK_CMP;
			lht_pkg::ST_LK_CMP: begin
				state_nxt = (idx_q + 1'b1 == fill_q) ? lht_pkg::ST_OUT : lht_pkg::ST_LK_RD;
			end
			lht_pkg::ST_INS: begin
				key_we    = 1'b1;
				fill_we   = 1'b1;
				state_nxt = lht_pkg::ST_LIM1;
			end
			lht_pkg::ST_LIM1: state_nxt = lht_pkg::ST_LIM2;
			lht_pkg::ST_LIM2: state_nxt = split_go ? lht_pkg::ST_SP_FILL_RD : lht_pkg::ST_ADDR;
			lht_pkg::ST_SP_FILL_RD: begin
				fill_raddr = split_ptr_q;
				state_nxt  = lht_pkg::ST_SP_FILL_WAIT;
			end
			lht_pkg::ST_SP_FILL_WAIT: begin
				fill_raddr = split_ptr_q;
				state_nxt  = (fill_cur == '0) ? lht_pkg::ST_SP_END_P : lht_pkg::ST_SP_RD;
			end
			lht_pkg::ST_SP_RD: begin
				key_raddr = {split_ptr_q, idx_q[lht_pkg::SLOT_W-1:0]};
				state_nxt = lht_pkg::ST_SP_DATA;
			end
			lht_pkg::ST_SP_DATA: state_nxt = lht_pkg::ST_SP_DIV;
			lht_pkg::ST_SP_DIV: begin
				if (div_cnt_q == lht_pkg::DIVC_W'(lht_pkg::DIV_CYC - 1))
					state_nxt = lht_pkg::ST_SP_MOVE;
			end
			lht_pkg::ST_SP_MOVE: begin
				key_wdata = mv_key_q;
				if (div_rem_q == lht_pkg::MOD_W'(split_ptr_q)) begin
					key_we    = 1'b1;
					key_waddr = {split_ptr_q, keep_q[lht_pkg::SLOT_W-1:0]};
				end else if (fillq_q < lht_pkg::FILL_W'(lht_pkg::SLOTS)) begin
					key_we    = 1'b1;
					key_waddr = {bucket_cnt_q[lht_pkg::BKT_W-1:0],
						fillq_q[lht_pkg::SLOT_W-1:0]};
				end
				state_nxt = (idx_q + 1'b1 == fill_q) ? lht_pkg::ST_SP_END_P : lht_pkg::ST_SP_RD;
			end
			lht_pkg::ST_SP_END_P: begin
				fill_we    = 1'b1;
				fill_waddr = split_ptr_q;
				fill_wdata = keep_q;
				state_nxt  = lht_pkg::ST_SP_END_Q;
			end
			lht_pkg::ST_SP_END_Q: begin
				fill_we    = 1'b1;
				fill_waddr = bucket_cnt_q[lht_pkg::BKT_W-1:0];
				fill_wdata = fillq_q;
				state_nxt  = lht_pkg::ST_LIM1;
			end
			lht_pkg::ST_OUT: begin
				if (out_free)
					state_nxt = lht_pkg::ST_IDLE;
			end
			default: state_nxt = lht_pkg::ST_IDLE;
		endcase
	end

	// table control state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q          <= lht_pkg::RST_INIT_BKT;
			cap_q        <= lht_pkg::RST_CAP;
			lim_q        <= lht_pkg::RST_LIMIT;
			level_q      <= '0;
			split_ptr_q  <= '0;
			bucket_cnt_q <= lht_pkg::RST_INIT_BKT;
			key_cnt_q    <= '0;
			vld_q        <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				lht_pkg::CFG_INIT_BKT: begin
					n_q          <= lht_pkg::clamp_buckets(cfg_data);
					level_q      <= '0;
					split_ptr_q  <= '0;
					bucket_cnt_q <= lht_pkg::clamp_buckets(cfg_data);
					key_cnt_q    <= '0;
					vld_q        <= '0;
				end
				lht_pkg::CFG_CAPACITY: cap_q <= cfg_data[lht_pkg::CAP_W-1:0];
				lht_pkg::CFG_LIMIT:    lim_q <= cfg_data[lht_pkg::LIM_W-1:0];
				default: ;
			endcase
		end else begin
			if (fill_we)
				vld_q[fill_waddr] <= 1'b1;
			if (state_q == lht_pkg::ST_INS)
				key_cnt_q <= key_cnt_q + 1'b1;
			if (state_q == lht_pkg::ST_SP_END_Q) begin
				bucket_cnt_q <= bucket_cnt_q + 1'b1;
				if (lht_pkg::MOD_W'(ptr_inc) >= rnd_m) begin
					split_ptr_q <= '0;
					level_q     <= level_q + 1'b1;
				end else begin
					split_ptr_q <= ptr_inc[lht_pkg::BKT_W-1:0];
				end
			end
		end
	end

	// operation datapath
	always_ff @(posedge clk) begin
		case (state_q)
			lht_pkg::ST_IDLE: begin
				type_q   <= req.req_type;
				key_q    <= req.key;
				fin_q    <= 1'b0;
				found_q  <= 1'b0;
				status_q <= 1'b0;
			end
			lht_pkg::ST_ADDR: begin
				div_num_q <= key_q;
				div_rem_q <= '0;
				div_d_q   <= rnd_m2;
				div_cnt_q <= '0;
			end
			lht_pkg::ST_DIV, lht_pkg::ST_SP_DIV: begin
				div_num_q <= div_num_nxt;
				div_rem_q <= div_rem_nxt;
				div_cnt_q <= div_cnt_q + 1'b1;
			end
			lht_pkg::ST_ADDR_RES: bkt_q <= bkt_nxt;
			lht_pkg::ST_FILL_WAIT: begin
				fill_q <= fill_cur;
				idx_q  <= '0;
				if (type_q == lht_pkg::REQ_INSERT && fill_cur >= lht_pkg::FILL_W'(lht_pkg::SLOTS))
					status_q <= 1'b1;
			end
			lht_pkg::ST_LK_CMP: begin
				if (key_rdata == key_q)
					found_q <= 1'b1;
				idx_q <= idx_q + 1'b1;
			end
			lht_pkg::ST_LIM1: begin
				lhs_q  <= lht_pkg::LOAD_W'(key_cnt_q) * lht_pkg::PCT_SCALE;
				prod_q <= lht_pkg::PROD_W'(lim_q) * lht_pkg::PROD_W'(bucket_cnt_q);
			end
			lht_pkg::ST_LIM2: fin_q <= 1'b1;
			lht_pkg::ST_SP_FILL_WAIT: begin
				fill_q  <= fill_cur;
				idx_q   <= '0;
				keep_q  <= '0;
				fillq_q <= '0;
			end
			lht_pkg::ST_SP_DATA: begin
				mv_key_q  <= key_rdata;
				div_num_q <= key_rdata;
				div_rem_q <= '0;
				div_d_q   <= rnd_m2;
				div_cnt_q <= '0;
			end
			lht_pkg::ST_SP_MOVE: begin
				if (div_rem_q == lht_pkg::MOD_W'(split_ptr_q))
					keep_q <= keep_q + 1'b1;
				else if (fillq_q < lht_pkg::FILL_W'(lht_pkg::SLOTS))
					fillq_q <= fillq_q + 1'b1;
				idx_q <= idx_q + 1'b1;
			end
			default: ;
		endcase
	end

	// output register: hold until the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (state_q == lht_pkg::ST_OUT && out_free)
			out_valid_q <= 1'b1;
		else if (rsp.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == lht_pkg::ST_OUT && out_free) begin
			out_found_q  <= found_q;
			out_status_q <= status_q;
			out_bkt_q    <= bkt_q;
			out_btot_q   <= bucket_cnt_q;
			out_rtot_q   <= key_cnt_q;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		lht_pkg::CNT_W'(split_ptr_q) < bucket_cnt_q)
		else $error("split pointer reached bucket count");

	assert property (@(posedge clk) disable iff (!arst_n)
		!$past(cfg_we) && bucket_cnt_q != $past(bucket_cnt_q) |->
		bucket_cnt_q == $past(bucket_cnt_q) + 1'b1)
		else $error("bucket count moved by more than one split");

	assert property (@(posedge clk) disable iff (!arst_n)
		!$past(cfg_we) && key_cnt_q != $past(key_cnt_q) |->
		key_cnt_q == $past(key_cnt_q) + 1'b1 && $past(state_q) == lht_pkg::ST_INS)
		else $error("record count changed outside an insert");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status |-> !rsp.found)
		else $error("dropped insert reported a hit");

endmodule

`default_nettype wire

// ----- verif/lht_table_checker.sv -----
`timescale 1ns / 1ps

module lht_table_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [lht_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lht_pkg::CFG_DATA_W-1:0]   cfg_data,
	lht_req_if                               req,
	lht_rsp_if                               rsp,
	output int                               errors,
	output int                               pending,
	output int                               drops,
	output int                               hits
);

	typedef struct packed {
		logic                      found;
		logic                      status;
		logic [lht_pkg::BKT_W-1:0] bucket_index;
		logic [lht_pkg::CNT_W-1:0] bucket_total;
		logic [lht_pkg::REC_W-1:0] record_total;
	} lht_result_t;

	lht_result_t               pending_results[$];

	logic [lht_pkg::CNT_W-1:0] init_reg;
	logic [lht_pkg::CAP_W-1:0] cap_reg;
	logic [lht_pkg::LIM_W-1:0] lim_reg;
	logic [lht_pkg::KEY_W-1:0] keys[lht_pkg::NUM_BKT][lht_pkg::SLOTS];
	int unsigned               fill[lht_pkg::NUM_BKT];
	int unsigned               level, ptr, bkt_cnt, key_cnt;

	assign pending = pending_results.size();

	function automatic longint unsigned base_n();
		longint unsigned n;
		n = 64'(init_reg);
		if (n < 1) n = 1;
		if (n > lht_pkg::NUM_BKT) n = lht_pkg::NUM_BKT;
		return n;
	endfunction

	function automatic void restart_table();
		foreach (fill[i]) fill[i] = 0;
		level = 0;
		ptr = 0;
		bkt_cnt = 32'(base_n());
		key_cnt = 0;
	endfunction

	function automatic int unsigned bucket_of(logic [lht_pkg::KEY_W-1:0] k);
		longint unsigned m, a;
		m = base_n() << level;
		a = k % m;
		if (a < ptr) a = k % (m << 1);
		return 32'(a);
	endfunction

	function automatic void split_bucket();
		int unsigned p, q, keep;
		longint unsigned m2;
		logic [lht_pkg::KEY_W-1:0] k;
		p = ptr;
		q = bkt_cnt;
		m2 = (base_n() << level) << 1;
		keep = 0;
		if (p >= lht_pkg::NUM_BKT || q >= lht_pkg::NUM_BKT) return;
		for (int i = 0; i < fill[p] && i < lht_pkg::SLOTS; i++) begin
			k = keys[p][i];
			if (k % m2 == p) begin
				keys[p][keep] = k;
				keep++;
			end else if (fill[q] < lht_pkg::SLOTS) begin
				keys[q][fill[q]] = k;
				fill[q]++;
			end
		end
		fill[p] = keep;
		bkt_cnt++;
		ptr++;
		if (ptr >= (base_n() << level)) begin
			ptr = 0;
			level++;
		end
	endfunction

	function automatic bit load_exceeded();
		longint unsigned lhs, rhs;
		lhs = longint'(key_cnt) * 100;
		rhs = longint'(lim_reg) * bkt_cnt * cap_reg;
		return lhs >= rhs;
	endfunction

	function automatic lht_result_t apply_request(logic rtype, logic [lht_pkg::KEY_W-1:0] k);
		lht_result_t r;
		int unsigned b;
		r = '0;
		b = bucket_of(k);
		if (b >= lht_pkg::NUM_BKT) b = lht_pkg::NUM_BKT - 1;
		if (rtype == lht_pkg::REQ_LOOKUP) begin
			for (int i = 0; i < fill[b] && i < lht_pkg::SLOTS; i++)
				if (keys[b][i] == k) r.found = 1'b1;
		end else if (fill[b] >= lht_pkg::SLOTS) begin
			r.status = 1'b1;
		end else begin
			keys[b][fill[b]] = k;
			fill[b]++;
			key_cnt++;
			while (bkt_cnt < lht_pkg::NUM_BKT && load_exceeded())
				split_bucket();
			b = bucket_of(k);
		end
		r.bucket_index = b[lht_pkg::BKT_W-1:0];
		r.bucket_total = bkt_cnt[lht_pkg::CNT_W-1:0];
		r.record_total = key_cnt[lht_pkg::REC_W-1:0];
		return r;
	endfunction

	task automatic report(string field, longint got, longint want);
		$display("[%0t] mismatch on %s: got %0d, want %0d", $time, field, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		lht_result_t want;
		if (!arst_n) begin
			init_reg = lht_pkg::RST_INIT_BKT;
			cap_reg = lht_pkg::RST_CAP;
			lim_reg = lht_pkg::RST_LIMIT;
			restart_table();
			pending_results.delete();
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (pending_results.size() == 0) begin
					$display("[%0t] result with no request outstanding", $time);
					errors++;
				end else begin
					want = pending_results.pop_front();
					if (rsp.found !== want.found) report("found", rsp.found, want.found);
					if (rsp.status !== want.status) report("status", rsp.status, want.status);
					if (rsp.bucket_index !== want.bucket_index)
						report("bucket_index", rsp.bucket_index, want.bucket_index);
					if (rsp.bucket_total !== want.bucket_total)
						report("bucket_total", rsp.bucket_total, want.bucket_total);
					if (rsp.record_total !== want.record_total)
						report("record_total", rsp.record_total, want.record_total);
					if (want.status) drops++;
					if (want.found) hits++;
				end
			end
			if (req.valid && req.ready)
				pending_results = {pending_results, apply_request(req.req_type, req.key)};
			if (cfg_we) begin
				case (cfg_index)
					lht_pkg::CFG_INIT_BKT: begin
						init_reg = cfg_data;
						restart_table();
					end
					lht_pkg::CFG_CAPACITY: cap_reg = cfg_data[lht_pkg::CAP_W-1:0];
					lht_pkg::CFG_LIMIT:    lim_reg = cfg_data;
					default:      ;
				endcase
			end
		end
	end

	initial begin
		errors = 0;
		drops = 0;
		hits = 0;
	end
endmodule

// ----- verif/linear_hash_table_test.sv -----
`timescale 1ns / 1ps

module linear_hash_table_test;

	localparam int CYCLE_LIMIT = 2000000;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [lht_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [lht_pkg::CFG_DATA_W-1:0] cfg_data;
	int                             errors, pending, drops, hits;
	int                             cycles;
	int                             sent;
	bit                             calm;
	bit                             hold_req;
	logic [lht_pkg::KEY_W-1:0]      stored_keys[$];

	lht_req_if req_ch();
	lht_rsp_if rsp_ch();

	linear_hash_table u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	lht_table_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.errors    (errors),
		.pending   (pending),
		.drops     (drops),
		.hits      (hits)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("status: fail");
			$finish;
		end
	end

	// Result side: random stall bursts, plus one long hold-off on request.
	initial begin
		int stall_left;
		stall_left = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				stall_left = 400;
			end
			if (stall_left > 0) begin
				rsp_ch.ready <= 1'b0;
				stall_left--;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				rsp_ch.ready <= 1'b0;
				stall_left = $urandom_range(0, 8);
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	task automatic send(logic rtype, logic [lht_pkg::KEY_W-1:0] k);
		if (!calm && $urandom_range(0, 3) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= rtype;
		req_ch.key <= k;
		do @(posedge clk); while (!req_ch.ready);
		if (rtype == lht_pkg::REQ_INSERT) stored_keys = {stored_keys, k};
		sent++;
	endtask

	// Drop valid and let every outstanding transaction drain.
	task automatic drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic write_regs(logic [6:0] init_v, logic [6:0] cap_v, logic [6:0] lim_v);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= lht_pkg::CFG_CAPACITY;
		cfg_data <= cap_v;
		@(posedge clk);
		cfg_index <= lht_pkg::CFG_LIMIT;
		cfg_data <= lim_v;
		@(posedge clk);
		cfg_index <= lht_pkg::CFG_INIT_BKT;
		cfg_data <= init_v;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		stored_keys.delete();
	endtask

	task automatic random_items(int count);
		int pick;
		logic [lht_pkg::KEY_W-1:0] k;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				k = ($urandom_range(0, 1) == 0) ? $urandom() : $urandom_range(0, 255);
				send(lht_pkg::REQ_INSERT, k);
			end else if (pick < 80 && stored_keys.size() > 0) begin
				send(lht_pkg::REQ_LOOKUP,
					stored_keys[$urandom_range(0, stored_keys.size() - 1)]);
			end else begin
				send(lht_pkg::REQ_LOOKUP, $urandom());
			end
		end
	endtask

	initial begin
		cycles = 0;
		sent = 0;
		calm = 1'b0;
		hold_req = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = lht_pkg::CFG_INIT_BKT;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.req_type = lht_pkg::REQ_INSERT;
		req_ch.key = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes, hit and miss, duplicates until the bucket overflows
		send(lht_pkg::REQ_INSERT, 32'h0);
		send(lht_pkg::REQ_INSERT, 32'hFFFF_FFFF);
		send(lht_pkg::REQ_LOOKUP, 32'h0);
		send(lht_pkg::REQ_LOOKUP, 32'hFFFF_FFFF);
		send(lht_pkg::REQ_LOOKUP, 32'h5);
		for (int i = 0; i < 17; i++) send(lht_pkg::REQ_INSERT, 32'h7);
		send(lht_pkg::REQ_LOOKUP, 32'h7);

		// unmapped register index must be ignored
		drain();
		cfg_we <= 1'b1;
		cfg_index <= 2'd3;
		cfg_data <= 7'h7F;
		@(posedge clk);
		cfg_we <= 1'b0;

		random_items(60);
		hold_req = 1'b1;
		random_items(20);
		drain();
		random_items(20);

		write_regs(7'd1, 7'd15, 7'd100);
		random_items(70);
		write_regs(7'd64, 7'd1, 7'd1);
		random_items(70);
		write_regs(7'd0, 7'd0, 7'd0);
		random_items(70);
		write_regs(7'h7F, 7'h7F, 7'h7F);
		random_items(70);
		write_regs(7'd5, 7'd2, 7'd50);
		random_items(70);
		write_regs(7'd2, 7'd15, 7'd1);
		random_items(60);
		write_regs(7'd16, 7'd8, 7'd90);
		calm = 1'b1;
		random_items(70);

		drain();
		$display("ran %0d requests over 8 register settings: %0d lookups hit, %0d inserts dropped",
			sent, hits, drops);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
